// ===== rtl/hlcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hlcd_pkg
// Shared constants and types for the header/length/checksum deframer.
// ----------------------------------------------------------------------------
package hlcd_pkg;

	// Payload buffer capacity and derived widths
	localparam int MAX_PAYLOAD = 32;
	localparam int ADDR_W      = $clog2(MAX_PAYLOAD);
	localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);

	// Fixed field widths of the result and configuration channels
	localparam int BYTE_W = 8;
	localparam int FLEN_W = 6;
	localparam int IDX_W  = 5;
	localparam int CFG_IDX_W = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 8'd1;

	// Reset values of the header registers
	localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'd170;
	localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'd85;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_EMPTY   = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	// Parser phases, one-hot
	typedef enum logic [5:0] {
		PH_HDR1  = 6'b000001,
		PH_HDR2  = 6'b000010,
		PH_CMD   = 6'b000100,
		PH_LEN   = 6'b001000,
		PH_DATA  = 6'b010000,
		PH_CHECK = 6'b100000
	} phase_t;

	// Frame hand-off from parser to replay engine
	typedef struct packed {
		logic              go;
		kind_t             kind;
		logic [BYTE_W-1:0] command;
		logic [FLEN_W-1:0] frame_length;
		logic [CNT_W-1:0]  count;
		logic [BYTE_W-1:0] expected_sum;
		logic [BYTE_W-1:0] received_sum;
	} start_t;

	// Replay engine status back to parser
	typedef struct packed {
		logic busy;
	} rep_status_t;

endpackage

// ===== rtl/hlcd_byte_if.sv =====
// ----------------------------------------------------------------------------
// hlcd_byte_if
// Received byte channel: valid/ready with one byte of payload.
// ----------------------------------------------------------------------------
interface hlcd_byte_if;
	import hlcd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== rtl/hlcd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// hlcd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface hlcd_cfg_if;
	import hlcd_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BYTE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/hlcd_result_if.sv =====
// ----------------------------------------------------------------------------
// hlcd_result_if
// Result channel: one decoded frame result per request.
// ----------------------------------------------------------------------------
interface hlcd_result_if;
	import hlcd_pkg::*;

	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [BYTE_W-1:0] command;
	logic [FLEN_W-1:0] frame_length;
	logic [IDX_W-1:0]  byte_index;
	logic [BYTE_W-1:0] payload_byte;
	logic [BYTE_W-1:0] expected_sum;
	logic [BYTE_W-1:0] received_sum;
	logic              last;

	modport source (output valid, output kind, output command, output frame_length,
		output byte_index, output payload_byte, output expected_sum,
		output received_sum, output last, input ready);
	modport sink   (input valid, input kind, input command, input frame_length,
		input byte_index, input payload_byte, input expected_sum,
		input received_sum, input last, output ready);
endinterface

// ===== rtl/hlcd_payload_ram.sv =====
// ----------------------------------------------------------------------------
// hlcd_payload_ram
// Payload buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hlcd_payload_ram (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [hlcd_pkg::ADDR_W-1:0]          waddr,
	input  logic [hlcd_pkg::BYTE_W-1:0]          wdata,
	input  logic                                 re,
	input  logic [hlcd_pkg::ADDR_W-1:0]          raddr,
	output logic [hlcd_pkg::BYTE_W-1:0]          rdata
);
	import hlcd_pkg::*;

	logic [BYTE_W-1:0] mem [MAX_PAYLOAD];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; data holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== rtl/hlcd_replay.sv =====
// ----------------------------------------------------------------------------
// hlcd_replay
// Replays a checked frame from the payload buffer, or sends a single
// empty-frame or checksum-error result, through an output register.
// ----------------------------------------------------------------------------
module hlcd_replay (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hlcd_pkg::start_t              start,
	output hlcd_pkg::rep_status_t         status,
	output logic                          rd_en,
	output logic [hlcd_pkg::ADDR_W-1:0]   rd_addr,
	input  logic [hlcd_pkg::BYTE_W-1:0]   rd_data,
	hlcd_result_if.source                 res
);
	import hlcd_pkg::*;

	// Frame info held for the whole replay
	kind_t             kind_q;
	logic [BYTE_W-1:0] command_q;
	logic [FLEN_W-1:0] flen_q;
	logic [CNT_W-1:0]  count_q;
	logic [BYTE_W-1:0] exp_q;
	logic [BYTE_W-1:0] rcv_q;

	// Sequencer control
	logic              act_q;
	logic              single_q;
	logic [CNT_W-1:0]  idx_q;

	// Read-in-flight stage
	logic              valid_s1;
	logic [CNT_W-1:0]  idx_s1;
	logic              last_s1;

	// Output register
	logic              out_valid_q;
	kind_t             out_kind_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	logic              out_load;
	logic              idx_last;

	assign out_load = !out_valid_q || res.ready;
	assign rd_en    = act_q && (!valid_s1 || out_load);
	assign rd_addr  = idx_q[ADDR_W-1:0];
	assign idx_last = ((idx_q + CNT_W'(1)) == count_q);
	// frame info feeds the result fields, so hold off until the last result is taken
	assign status.busy = act_q || single_q || valid_s1 || out_valid_q;

	// Frame info capture
	always_ff @(posedge clk) begin
		if (start.go) begin
			kind_q    <= start.kind;
			command_q <= start.command;
			flen_q    <= start.frame_length;
			count_q   <= start.count;
			exp_q     <= start.expected_sum;
			rcv_q     <= start.received_sum;
		end
	end

	// Read sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q       <= 1'b0;
			single_q    <= 1'b0;
			idx_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start.go) begin
				if (start.kind == KIND_PAYLOAD) begin
					act_q <= 1'b1;
					idx_q <= '0;
				end else begin
					single_q <= 1'b1;
				end
			end else begin
				if (rd_en) begin
					idx_q <= idx_q + CNT_W'(1);
					if (idx_last) begin
						act_q <= 1'b0;
					end
				end
				if (out_load && !valid_s1) begin
					single_q <= 1'b0;
				end
			end
			if (rd_en) begin
				valid_s1 <= 1'b1;
			end else if (out_load) begin
				valid_s1 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= valid_s1 || single_q;
			end
		end
	end

	// Stage and output payload
	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1  <= idx_q;
			last_s1 <= idx_last;
		end
		if (out_load) begin
			if (valid_s1) begin
				out_kind_q <= KIND_PAYLOAD;
				out_idx_q  <= IDX_W'(idx_s1);
				out_byte_q <= rd_data;
				out_last_q <= last_s1;
			end else begin
				out_kind_q <= kind_q;
				out_idx_q  <= '0;
				out_byte_q <= '0;
				out_last_q <= 1'b1;
			end
		end
	end

	assign res.valid        = out_valid_q;
	assign res.kind         = out_kind_q;
	assign res.command      = command_q;
	assign res.frame_length = flen_q;
	assign res.byte_index   = out_idx_q;
	assign res.payload_byte = out_byte_q;
	assign res.expected_sum = exp_q;
	assign res.received_sum = rcv_q;
	assign res.last         = out_last_q;
endmodule

// ===== rtl/header_length_checksum_deframer_core.sv =====
// ----------------------------------------------------------------------------
// header_length_checksum_deframer_core
// Byte-serial frame parser with payload buffer and result replay.
// ----------------------------------------------------------------------------
// Usage:
//   rx   : received bytes, one per request. Frame = header_first,
//          header_second, command, length, payload, additive checksum.
//   res  : results. A good frame gives one result per payload byte (or one
//          for an empty frame), a bad checksum one error result.
//   cfg  : header register writes (index 0 first, 1 second), always ready.
//          Rule for the user, not enforced: taken only while the block is idle.
// Throughput: one received byte per cycle while parsing. After the checksum
//   byte the input is held off until the frame's last result has been taken:
//   one result per cycle from the payload buffer's single read port while
//   the receiver does not stall.
// Results: a single result goes via a pending flag to the output register;
//   a replay goes via the buffer's registered read and the output register.
// Reset: parser hunts for the first header, headers return to 0xAA/0x55.
//   The payload buffer is not cleared; only written entries are replayed.
// Receiver stall: results wait in the output register; replay pauses and
//   the input stays held off.
// ----------------------------------------------------------------------------
module header_length_checksum_deframer_core (
	input  logic          clk,
	input  logic          arst_n,
	hlcd_byte_if.sink     rx,
	hlcd_cfg_if.sink      cfg,
	hlcd_result_if.source res
);
	import hlcd_pkg::*;

	// Configuration and parser state
	logic [BYTE_W-1:0] hdr1_q;
	logic [BYTE_W-1:0] hdr2_q;
	phase_t            phase_q;
	logic [BYTE_W-1:0] cmd_q;
	logic [BYTE_W-1:0] len_q;
	logic [CNT_W-1:0]  fill_q;
	logic [BYTE_W-1:0] sum_q;

	logic              rx_fire;
	logic              room;
	logic              ram_we;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;
	start_t            start;
	rep_status_t       status;

	assign rx.ready  = !status.busy;
	assign rx_fire   = rx.valid && rx.ready;
	assign cfg.ready = 1'b1;

	// Buffer has room for another payload byte
	assign room = ({{(BYTE_W-CNT_W){1'b0}}, fill_q} < len_q)
		&& (fill_q < CNT_W'(MAX_PAYLOAD));
	assign ram_we = rx_fire && (phase_q == PH_DATA) && room;

	// Frame hand-off on checksum byte
	always_comb begin
		start.go           = rx_fire && (phase_q == PH_CHECK);
		start.command      = cmd_q;
		start.frame_length = len_q[FLEN_W-1:0];
		start.count        = CNT_W'(len_q);
		start.expected_sum = sum_q;
		start.received_sum = rx.rx_byte;
		if (rx.rx_byte != sum_q) begin
			start.kind = KIND_ERROR;
		end else if (len_q == '0) begin
			start.kind = KIND_EMPTY;
		end else begin
			start.kind = KIND_PAYLOAD;
		end
	end

	// Header registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr1_q <= HEADER_FIRST_RST;
			hdr2_q <= HEADER_SECOND_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_HEADER_FIRST:  hdr1_q <= cfg.data;
				REG_HEADER_SECOND: hdr2_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR1;
			cmd_q   <= '0;
			len_q   <= '0;
			fill_q  <= '0;
			sum_q   <= '0;
		end else if (rx_fire) begin
			case (phase_q)
				PH_HDR1: begin
					if (rx.rx_byte == hdr1_q) begin
						phase_q <= PH_HDR2;
					end
				end
				PH_HDR2: begin
					phase_q <= (rx.rx_byte == hdr2_q) ? PH_CMD : PH_HDR1;
				end
				PH_CMD: begin
					cmd_q   <= rx.rx_byte;
					phase_q <= PH_LEN;
				end
				PH_LEN: begin
					len_q   <= rx.rx_byte;
					fill_q  <= '0;
					sum_q   <= cmd_q + rx.rx_byte;
					phase_q <= (rx.rx_byte != '0) ? PH_DATA : PH_CHECK;
				end
				PH_DATA: begin
					if (room) begin
						fill_q <= fill_q + CNT_W'(1);
						sum_q  <= sum_q + rx.rx_byte;
						if ({{(BYTE_W-CNT_W){1'b0}}, fill_q + CNT_W'(1)} >= len_q) begin
							phase_q <= PH_CHECK;
						end
					end else begin
						phase_q <= PH_HDR1;
					end
				end
				PH_CHECK: begin
					phase_q <= PH_HDR1;
				end
				default: begin
					phase_q <= PH_HDR1;
				end
			endcase
		end
	end

	hlcd_payload_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (fill_q[ADDR_W-1:0]),
		.wdata (rx.rx_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	hlcd_replay u_replay (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.status  (status),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata),
		.res     (res)
	);
endmodule

// ===== dv/header_length_checksum_deframer_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// header_length_checksum_deframer_core_test
// Self-checking bench for the byte-serial frame deframer. Frames, broken
// frames and noise go in through the rx channel. A cycle-level predictor
// tracks the parser and queues the expected replay or error results. The
// monitor compares each result request against the oldest expectation.
// The header registers are rewritten between traffic phases while the
// block is idle.
// ----------------------------------------------------------------------------
module header_length_checksum_deframer_core_test;
	import hlcd_pkg::*;

	localparam int NUM_PHASES   = 5;
	localparam int ITEM_TARGET  = 220;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;
	localparam int HOLD_AFTER   = 12;
	localparam int CYCLE_LIMIT  = 300000;
	// index past the register list, the write must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd255;

	typedef struct {
		kind_t             kind;
		logic [BYTE_W-1:0] command;
		logic [FLEN_W-1:0] frame_length;
		logic [IDX_W-1:0]  byte_index;
		logic [BYTE_W-1:0] payload_byte;
		logic [BYTE_W-1:0] expected_sum;
		logic [BYTE_W-1:0] received_sum;
		logic              last;
	} frame_result_t;

	logic clk;
	logic arst_n;

	hlcd_byte_if   rx_ch ();
	hlcd_cfg_if    cfg_ch ();
	hlcd_result_if res_ch ();

	header_length_checksum_deframer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.cfg    (cfg_ch),
		.res    (res_ch)
	);

	// Parser shadow state and header registers
	logic [BYTE_W-1:0] hdr_first;
	logic [BYTE_W-1:0] hdr_second;
	phase_t            parse_ph = PH_HDR1;
	logic [BYTE_W-1:0] held_cmd = '0;
	logic [BYTE_W-1:0] held_len = '0;
	int                fill_cnt = 0;
	logic [BYTE_W-1:0] run_sum  = '0;
	logic [BYTE_W-1:0] payload_buf [MAX_PAYLOAD];

	logic [BYTE_W-1:0] rx_backlog [$];
	frame_result_t     expected_results [$];

	int          errors = 0;
	int          results_seen;
	int unsigned rx_gap;
	int unsigned res_stall;
	bit          rx_busy;
	bit          res_busy;
	bit          long_hold;
	bit          hold_done;
	int          hold_left;
	int          cycle_count = 0;

	function automatic int unsigned draw_wait(input bit busy);
		return busy ? $urandom_range(0, 15) : 0;
	endfunction

	// Advance the parser by one received byte, queue any results it causes
	task automatic parse_rx_byte(input logic [BYTE_W-1:0] b);
		frame_result_t r;
		int            n_out;
		case (parse_ph)
			PH_HDR1: begin
				if (b == hdr_first)
					parse_ph = PH_HDR2;
			end
			PH_HDR2: begin
				parse_ph = (b == hdr_second) ? PH_CMD : PH_HDR1;
			end
			PH_CMD: begin
				held_cmd = b;
				parse_ph = PH_LEN;
			end
			PH_LEN: begin
				held_len = b;
				fill_cnt = 0;
				run_sum  = held_cmd + b;
				parse_ph = (b != 0) ? PH_DATA : PH_CHECK;
			end
			PH_DATA: begin
				if (fill_cnt < held_len && fill_cnt < MAX_PAYLOAD) begin
					payload_buf[fill_cnt] = b;
					fill_cnt++;
					run_sum = run_sum + b;
					if (fill_cnt >= held_len)
						parse_ph = PH_CHECK;
				end else begin
					// oversize frame: dropped silently
					parse_ph = PH_HDR1;
				end
			end
			PH_CHECK: begin
				r.command      = held_cmd;
				r.frame_length = held_len[FLEN_W-1:0];
				r.expected_sum = run_sum;
				r.received_sum = b;
				r.byte_index   = '0;
				r.payload_byte = '0;
				r.last         = 1'b1;
				if (b != run_sum) begin
					r.kind = KIND_ERROR;
					expected_results.push_back(r);
				end else if (held_len == 0) begin
					r.kind = KIND_EMPTY;
					expected_results.push_back(r);
				end else begin
					// replay the buffered payload
					n_out  = (held_len > MAX_PAYLOAD) ? MAX_PAYLOAD : held_len;
					r.kind = KIND_PAYLOAD;
					for (int i = 0; i < n_out; i++) begin
						r.byte_index   = i[IDX_W-1:0];
						r.payload_byte = payload_buf[i];
						r.last         = (i + 1 == n_out);
						expected_results.push_back(r);
					end
				end
				parse_ph = PH_HDR1;
			end
			default: parse_ph = PH_HDR1;
		endcase
	endtask

	task automatic check_field(input string what, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			errors++;
		end
	endtask

	// Queue one frame; lengths past the buffer get one extra byte, then drop
	task automatic queue_frame(input logic [BYTE_W-1:0] cmd, input int len,
		input bit good, output int n);
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] b;
		int                stored;
		stored = (len > MAX_PAYLOAD) ? MAX_PAYLOAD : len;
		rx_backlog.push_back(hdr_first);
		rx_backlog.push_back(hdr_second);
		rx_backlog.push_back(cmd);
		rx_backlog.push_back(len[7:0]);
		sum = cmd + len[7:0];
		for (int i = 0; i < stored; i++) begin
			b = 8'($urandom_range(0, 255));
			rx_backlog.push_back(b);
			sum = sum + b;
		end
		if (len > MAX_PAYLOAD) begin
			b = 8'($urandom_range(0, 255));
			rx_backlog.push_back(b);
		end else begin
			b = good ? sum : sum + 8'($urandom_range(1, 255));
			rx_backlog.push_back(b);
		end
		n = stored + 5;
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_HEADER_FIRST)
			hdr_first = val;
		else if (idx == REG_HEADER_SECOND)
			hdr_second = val;
	endtask

	// Wait until all bytes are taken and all results are back, then settle
	task automatic wait_idle();
		do @(posedge clk);
		while (rx_backlog.size() != 0 || rx_ch.valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Byte driver: one request per backlog entry, random gap after each if rx_busy
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ch.valid   <= 1'b0;
			rx_ch.rx_byte <= '0;
			rx_gap        <= 0;
		end else begin
			if (rx_ch.valid && rx_ch.ready)
				parse_rx_byte(rx_ch.rx_byte);
			if (!rx_ch.valid || rx_ch.ready) begin
				if (rx_gap != 0) begin
					rx_gap      <= rx_gap - 1;
					rx_ch.valid <= 1'b0;
				end else if (rx_backlog.size() != 0) begin
					rx_ch.valid   <= 1'b1;
					rx_ch.rx_byte <= rx_backlog.pop_front();
					rx_gap        <= draw_wait(rx_busy);
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and checker
	always @(posedge clk or negedge arst_n) begin : result_monitor
		int unsigned   stall;
		frame_result_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			res_stall    <= 0;
			results_seen <= 0;
		end else begin
			stall = (res_stall != 0) ? res_stall - 1 : 0;
			if (res_ch.valid && res_ch.ready) begin
				results_seen <= results_seen + 1;
				stall = draw_wait(res_busy);
				if (expected_results.size() == 0) begin
					$display("%0t: result mismatch, expected none, actual kind %0d cmd %0h idx %0d",
						$time, res_ch.kind, res_ch.command, res_ch.byte_index);
					errors++;
				end else begin
					want = expected_results.pop_front();
					check_field("kind", 8'(want.kind), 8'(res_ch.kind));
					check_field("command", want.command, res_ch.command);
					check_field("frame_length", 8'(want.frame_length),
						8'(res_ch.frame_length));
					check_field("byte_index", 8'(want.byte_index), 8'(res_ch.byte_index));
					check_field("payload_byte", want.payload_byte, res_ch.payload_byte);
					check_field("expected_sum", want.expected_sum, res_ch.expected_sum);
					check_field("received_sum", want.received_sum, res_ch.received_sum);
					check_field("last", 8'(want.last), 8'(res_ch.last));
				end
			end
			res_stall    <= stall;
			res_ch.ready <= (stall == 0) && !long_hold;
		end
	end

	// One long receiver hold-off while bytes are still being offered
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_hold <= 1'b0;
			hold_done <= 1'b0;
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			if (hold_left == 1)
				long_hold <= 1'b0;
		end else if (!hold_done && results_seen >= HOLD_AFTER && rx_ch.valid) begin
			long_hold <= 1'b1;
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("header_length_checksum_deframer_core verification failed");
			$finish;
		end
	end

	// Stimulus
	initial begin : stimulus
		int                n;
		int                pick;
		int                len;
		int                counted;
		logic [BYTE_W-1:0] b;
		logic [BYTE_W-1:0] set_first;
		logic [BYTE_W-1:0] set_second;

		arst_n        = 1'b0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = '0;
		cfg_ch.data   = '0;
		rx_busy       = 1'b1;
		res_busy      = 1'b1;
		hdr_first     = HEADER_FIRST_RST;
		hdr_second    = HEADER_SECOND_RST;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty frame, repeated first header, bad checksum, noise, good frame
		queue_frame(8'hFF, 0, 1'b1, n);
		rx_backlog.push_back(hdr_first);
		rx_backlog.push_back(hdr_first);
		queue_frame(8'h00, 1, 1'b0, n);
		rx_backlog.push_back(8'h00);
		queue_frame(8'h80, 2, 1'b1, n);
		counted = 20;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			if (ph != 0) begin
				wait_idle();
				case (ph)
					1: begin set_first = 8'h00; set_second = 8'hFF; end
					2: begin set_first = 8'hFF; set_second = 8'h00; end
					3: begin set_first = 8'h3C; set_second = 8'h3C; end
					default: begin
						set_first  = 8'($urandom_range(0, 255));
						set_second = 8'($urandom_range(0, 255));
					end
				endcase
				cfg_write(REG_HEADER_FIRST, set_first);
				cfg_write(REG_HEADER_SECOND, set_second);
				if (ph == 2)
					cfg_write(REG_UNUSED, 8'($urandom_range(0, 255)));
			end
			// idle pattern per phase, including stretches without gaps
			rx_busy  <= (ph != 1 && ph != 3);
			res_busy <= (ph != 1 && ph != 2);
			if (ph == 1) begin
				queue_frame(8'($urandom_range(0, 255)), MAX_PAYLOAD, 1'b1, n);
				queue_frame(8'($urandom_range(0, 255)), MAX_PAYLOAD + 1, 1'b1, n);
				counted += 2 * MAX_PAYLOAD + 11;
			end
			while (counted < (ph + 1) * ITEM_TARGET / NUM_PHASES) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					// good frame, mostly short
					case ($urandom_range(0, 9))
						0: len = 0;
						1: len = MAX_PAYLOAD;
						2: len = $urandom_range(9, MAX_PAYLOAD - 1);
						default: len = $urandom_range(1, 8);
					endcase
					queue_frame(8'($urandom_range(0, 255)), len, 1'b1, n);
				end else if (pick < 80) begin
					queue_frame(8'($urandom_range(0, 255)), $urandom_range(0, 8), 1'b0, n);
				end else if (pick < 88) begin
					// first header then a wrong second byte
					rx_backlog.push_back(hdr_first);
					if (hdr_first != hdr_second && $urandom_range(0, 1))
						b = hdr_first;
					else
						do b = 8'($urandom_range(0, 255)); while (b == hdr_second);
					rx_backlog.push_back(b);
					n = 2;
				end else if (pick < 93) begin
					len = ($urandom_range(0, 2) == 0) ? 255 : $urandom_range(MAX_PAYLOAD + 1, 254);
					queue_frame(8'($urandom_range(0, 255)), len, 1'b1, n);
				end else begin
					// line noise between frames
					n = $urandom_range(1, 3);
					repeat (n) begin
						do b = 8'($urandom_range(0, 255)); while (b == hdr_first);
						rx_backlog.push_back(b);
					end
				end
				counted += n;
			end
		end

		wait_idle();
		if (errors == 0)
			$display("header_length_checksum_deframer_core verification clean");
		else
			$display("header_length_checksum_deframer_core verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/hlcd_pkg.sv
rtl/hlcd_byte_if.sv
rtl/hlcd_cfg_if.sv
rtl/hlcd_result_if.sv
rtl/hlcd_payload_ram.sv
rtl/hlcd_replay.sv
rtl/header_length_checksum_deframer_core.sv
dv/header_length_checksum_deframer_core_test.sv
